// File: src/sbsd_pkg.sv
// shared types and constants for the squared distance sorter
`default_nettype none
package sbsd_pkg;
  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W = 6;
  localparam int POS_W = 16;
  localparam int DIST_W = 34;
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W = $clog2(Q_DEPTH);

  localparam logic [1:0] REG_REF_X = 2'd0;
  localparam logic [1:0] REG_REF_Y = 2'd1;
  localparam logic [1:0] REG_REF_Z = 2'd2;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] dsq;
    logic              last;
  } sbsd_item_t;
endpackage
`default_nettype wire

// File: src/sbsd_front.sv
// front end: register file and two stage squared distance datapath
`default_nettype none
module sbsd_front
  import sbsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_idx,
  input  wire logic [POS_W-1:0]  cfg_data,
  output logic [POS_W-1:0]       ref_x,
  output logic [POS_W-1:0]       ref_y,
  output logic [POS_W-1:0]       ref_z,
  input  wire logic              acc,
  input  wire logic [ID_W-1:0]   in_id,
  input  wire logic [POS_W-1:0]  in_x,
  input  wire logic [POS_W-1:0]  in_y,
  input  wire logic [POS_W-1:0]  in_z,
  input  wire logic              in_last,
  output logic                   q_push,
  output sbsd_item_t             q_item
);
  logic [POS_W-1:0] rx_r, ry_r, rz_r;
  logic             v1_r, v2_r;
  logic [ID_W-1:0]  id1_r, id2_r;
  logic             l1_r, l2_r;
  logic signed [POS_W:0] dx_r, dy_r, dz_r;
  logic [2*POS_W+1:0] sx_r, sy_r, sz_r;
  logic signed [POS_W:0] dx, dy, dz;
  logic signed [2*POS_W+1:0] sqx, sqy, sqz;

  assign ref_x = rx_r;
  assign ref_y = ry_r;
  assign ref_z = rz_r;
  assign dx = $signed({in_x[POS_W-1], in_x}) - $signed({rx_r[POS_W-1], rx_r});
  assign dy = $signed({in_y[POS_W-1], in_y}) - $signed({ry_r[POS_W-1], ry_r});
  assign dz = $signed({in_z[POS_W-1], in_z}) - $signed({rz_r[POS_W-1], rz_r});
  assign sqx = dx_r * dx_r;
  assign sqy = dy_r * dy_r;
  assign sqz = dz_r * dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r <= '0;
      ry_r <= '0;
      rz_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_REF_X: rx_r <= cfg_data;
          REG_REF_Y: ry_r <= cfg_data;
          REG_REF_Z: rz_r <= cfg_data;
          default: ;
        endcase
      end
      v1_r <= acc;
      v2_r <= v1_r;
    end
    dx_r  <= dx;
    dy_r  <= dy;
    dz_r  <= dz;
    id1_r <= in_id;
    l1_r  <= in_last;
    sx_r  <= $unsigned(sqx);
    sy_r  <= $unsigned(sqy);
    sz_r  <= $unsigned(sqz);
    id2_r <= id1_r;
    l2_r  <= l1_r;
  end

  assign q_push      = v2_r;
  assign q_item.id   = id2_r;
  assign q_item.dsq  = DIST_W'(sx_r) + DIST_W'(sy_r) + DIST_W'(sz_r);
  assign q_item.last = l2_r;
endmodule
`default_nettype wire

// File: src/sbsd_queue.sv
// short fifo between front and back
`default_nettype none
module sbsd_queue
  import sbsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  sbsd_item_t      din,
  input  wire logic       pop,
  output logic            not_empty,
  output logic            empty,
  output sbsd_item_t      dout
);
  sbsd_item_t      mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
    if (push) mem_r[wp_r] <= din;
  end

  assign not_empty = (cnt_r != '0);
  assign empty     = (cnt_r == '0);
  assign dout      = mem_r[rp_r];
endmodule
`default_nettype wire

// File: src/sbsd_back.sv
// back end: systolic insertion sorter with drain
`default_nettype none
module sbsd_back
  import sbsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_ne,
  input  sbsd_item_t             q_item,
  output logic                   q_pop,
  output logic                   busy_back,
  output logic                   out_valid,
  output logic [ID_W-1:0]        out_id,
  output logic [DIST_W-1:0]      out_dist,
  output logic                   out_end,
  output logic                   out_ovf
);
  typedef enum logic [1:0] { ST_LOAD = 2'b01, ST_DRAIN = 2'b10 } st_t;
  st_t st_r;
  logic [ID_W-1:0]   id_r   [MAX_ENTRIES];
  logic [DIST_W-1:0] d_r    [MAX_ENTRIES];
  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;
  logic              ins;
  logic [MAX_ENTRIES-1:0] gt;

  assign q_pop     = (st_r == ST_LOAD) && q_ne;
  assign busy_back = (st_r == ST_DRAIN);
  assign ins       = q_pop && (cnt_r < CNT_W'(MAX_ENTRIES));

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++)
      gt[i] = (CNT_W'(i) < cnt_r) && (d_r[i] > q_item.dsq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_LOAD;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      case (st_r)
        ST_LOAD: begin
          if (q_pop) begin
            if (ins) cnt_r <= cnt_r + 1'b1;
            else ovf_r <= 1'b1;
            if (q_item.last) st_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (cnt_r <= CNT_W'(1)) begin
            cnt_r <= '0;
            ovf_r <= 1'b0;
            st_r  <= ST_LOAD;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        default: st_r <= ST_LOAD;
      endcase
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (st_r == ST_DRAIN) begin
        if (i < MAX_ENTRIES - 1) begin
          id_r[i] <= id_r[(i < MAX_ENTRIES - 1) ? i+1 : i];
          d_r[i]  <= d_r[(i < MAX_ENTRIES - 1) ? i+1 : i];
        end
      end else if (ins) begin
        if (gt[i]) begin
          if (i > 0 && gt[(i > 0) ? i-1 : 0]) begin
            id_r[i] <= id_r[(i > 0) ? i-1 : 0];
            d_r[i]  <= d_r[(i > 0) ? i-1 : 0];
          end else begin
            id_r[i] <= q_item.id;
            d_r[i]  <= q_item.dsq;
          end
        end else if (CNT_W'(i) == cnt_r) begin
          if (i > 0 && gt[(i > 0) ? i-1 : 0]) begin
            id_r[i] <= id_r[(i > 0) ? i-1 : 0];
            d_r[i]  <= d_r[(i > 0) ? i-1 : 0];
          end else begin
            id_r[i] <= q_item.id;
            d_r[i]  <= q_item.dsq;
          end
        end
      end
    end
  end

  assign out_valid = (st_r == ST_DRAIN) && (cnt_r != '0);
  assign out_id    = id_r[0];
  assign out_dist  = d_r[0];
  assign out_end   = (cnt_r == CNT_W'(1));
  assign out_ovf   = ovf_r;
endmodule
`default_nettype wire

// File: src/sort_by_squared_distance.sv
// top level of the nearest first squared distance sorter
// after the last entry passes the front pipeline and queue, results follow one per cycle
// throughput: one entry per cycle while loading; busy after the last entry until the drain ends
// the drain shifts the sorter array one rank per cycle
// reset: synchronous active low, clears reference registers, valid bits, state, counts and overflow flag
// results cannot be stalled by the receiver
`default_nettype none
module sort_by_squared_distance
  import sbsd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [ID_W-1:0]    in_entry_id,
  input  wire logic [POS_W-1:0]   in_pos_x,
  input  wire logic [POS_W-1:0]   in_pos_y,
  input  wire logic [POS_W-1:0]   in_pos_z,
  input  wire logic               in_is_last,
  output logic                    out_valid,
  output logic [ID_W-1:0]         out_sorted_id,
  output logic [DIST_W-1:0]       out_dist_sq,
  output logic                    out_end_of_run,
  output logic                    out_overflowed,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  logic acc, pend_r, q_push, q_pop, q_ne, q_empty, busy_back, cfg_we;
  sbsd_item_t q_in, q_out;
  logic [POS_W-1:0] rx, ry, rz;
  logic [2:0] inflight_r;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[1:0] == 2'b00);
  assign acc    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      inflight_r <= '0;
    end else begin
      inflight_r <= {inflight_r[1:0], acc};
      if (acc && in_is_last) pend_r <= 1'b1;
      else if (busy_back) pend_r <= 1'b0;
    end
  end

  assign busy = pend_r || busy_back;

  always_comb begin
    case (paddr[3:2])
      REG_REF_X: prdata = {{(32-POS_W){rx[POS_W-1]}}, rx};
      REG_REF_Y: prdata = {{(32-POS_W){ry[POS_W-1]}}, ry};
      REG_REF_Z: prdata = {{(32-POS_W){rz[POS_W-1]}}, rz};
      default:   prdata = '0;
    endcase
  end

  sbsd_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_idx(paddr[3:2]), .cfg_data(pwdata[POS_W-1:0]),
    .ref_x(rx), .ref_y(ry), .ref_z(rz), .acc,
    .in_id(in_entry_id), .in_x(in_pos_x), .in_y(in_pos_y), .in_z(in_pos_z),
    .in_last(in_is_last), .q_push, .q_item(q_in)
  );

  sbsd_queue u_queue (
    .clk, .rst_n, .push(q_push), .din(q_in), .pop(q_pop),
    .not_empty(q_ne), .empty(q_empty), .dout(q_out)
  );

  sbsd_back u_back (
    .clk, .rst_n, .q_ne, .q_item(q_out), .q_pop, .busy_back,
    .out_valid, .out_id(out_sorted_id), .out_dist(out_dist_sq),
    .out_end(out_end_of_run), .out_ovf(out_overflowed)
  );

  a_no_drain_with_queue: assert property (@(posedge clk) disable iff (!rst_n)
    busy_back |-> q_empty) else $error("queue not empty during drain");
  a_end_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_end_of_run && out_valid |=> !out_valid) else $error("result after end of run");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_back |-> inflight_r == 3'b000) else $error("beat in flight during drain");
endmodule
`default_nettype wire

// File: tb/sbsd_checker.sv
// checker for the squared distance sorter: watches the channels, predicts the ranked output
module sbsd_checker
  import sbsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [ID_W-1:0]   in_entry_id,
  input  wire logic [POS_W-1:0]  in_pos_x,
  input  wire logic [POS_W-1:0]  in_pos_y,
  input  wire logic [POS_W-1:0]  in_pos_z,
  input  wire logic              in_is_last,
  input  wire logic              out_valid,
  input  wire logic [ID_W-1:0]   out_sorted_id,
  input  wire logic [DIST_W-1:0] out_dist_sq,
  input  wire logic              out_end_of_run,
  input  wire logic              out_overflowed,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  input  wire logic              pready,
  output int                     errors,
  output int                     ranks_pending
);

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] dsq;
    logic              eor;
    logic              ovf;
  } rank_t;

  rank_t ranked_q[$];
  logic signed [POS_W-1:0] point_x, point_y, point_z;
  logic [DIST_W-1:0] held_dist [MAX_ENTRIES];
  logic [ID_W-1:0]   held_id [MAX_ENTRIES];
  int held_count;
  logic dropped;

  assign ranks_pending = ranked_q.size();

  function automatic logic [DIST_W-1:0] sq_dist(logic signed [POS_W-1:0] px, py, pz);
    logic signed [POS_W:0] dx, dy, dz;
    logic signed [DIST_W:0] sum;
    dx = px - point_x;
    dy = py - point_y;
    dz = pz - point_z;
    sum = dx * dx + dy * dy + dz * dz;
    return sum[DIST_W-1:0];
  endfunction

  task automatic load_entry();
    int order [MAX_ENTRIES];
    int j;
    rank_t r;
    if (held_count < MAX_ENTRIES) begin
      held_dist[held_count] = sq_dist(in_pos_x, in_pos_y, in_pos_z);
      held_id[held_count] = in_entry_id;
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (!in_is_last) return;
    // stable insertion sort, ties keep load order
    for (int i = 0; i < held_count; i++) begin
      j = i;
      while (j > 0 && held_dist[order[j-1]] > held_dist[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (int i = 0; i < held_count; i++) begin
      r.id = held_id[order[i]];
      r.dsq = held_dist[order[i]];
      r.eor = (i == held_count - 1);
      r.ovf = dropped;
      ranked_q.push_back(r);
    end
    held_count = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    rank_t e;
    if (!rst_n) begin
      point_x = '0;
      point_y = '0;
      point_z = '0;
      held_count = 0;
      dropped = 1'b0;
      errors = 0;
      ranked_q.delete();
    end else begin
      if (out_valid) begin
        if (ranked_q.size() == 0) begin
          $display("%0t: unexpected beat id %0d dist %0d", $time, out_sorted_id, out_dist_sq);
          errors++;
        end else begin
          e = ranked_q.pop_front();
          if (out_sorted_id !== e.id) begin
            $display("%0t: sorted_id expected %0d actual %0d", $time, e.id, out_sorted_id);
            errors++;
          end
          if (out_dist_sq !== e.dsq) begin
            $display("%0t: dist_sq expected %0d actual %0d", $time, e.dsq, out_dist_sq);
            errors++;
          end
          if (out_end_of_run !== e.eor) begin
            $display("%0t: end_of_run expected %0b actual %0b", $time, e.eor, out_end_of_run);
            errors++;
          end
          if (out_overflowed !== e.ovf) begin
            $display("%0t: overflowed expected %0b actual %0b", $time, e.ovf, out_overflowed);
            errors++;
          end
        end
      end
      if (start && !busy) load_entry();
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_REF_X: point_x = pwdata[POS_W-1:0];
          REG_REF_Y: point_y = pwdata[POS_W-1:0];
          REG_REF_Z: point_z = pwdata[POS_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/testbench.sv
// top of the squared distance sorter testbench: clock, reset, stimulus and verdict
module testbench;
  import sbsd_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [ID_W-1:0] in_entry_id = '0;
  logic [POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic in_is_last = 1'b0;
  logic out_valid, out_end_of_run, out_overflowed;
  logic [ID_W-1:0] out_sorted_id;
  logic [DIST_W-1:0] out_dist_sq;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors, ranks_pending;
  bit gaps_on;
  int sent;
  logic [POS_W-1:0] tie_x;

  always #10 clk = ~clk;

  sort_by_squared_distance u_top (.*);

  sbsd_checker u_chk (.*);

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_entry(logic [ID_W-1:0] id, logic [POS_W-1:0] x, y, z, logic last);
    while (gaps_on && $urandom_range(99) < 38) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_entry_id <= id;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_is_last <= last;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (ranks_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_set(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_entry(ID_W'($urandom), tie_x, tie_x, tie_x, i == n - 1);
      else
        send_entry(ID_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                   POS_W'($urandom), i == n - 1);
    end
  endtask

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int n;
    gaps_on = 1'b1;
    sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // extremes at reset reference point
    send_entry(6'd0, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_entry(6'd63, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send_entry(6'd21, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_entry(6'd42, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    settle();
    write_reg(REG_REF_X, 32'hffff_7fff);
    write_reg(REG_REF_Y, 32'h0000_7fff);
    write_reg(REG_REF_Z, 32'h0000_8000);
    write_reg(REG_UNUSED, 32'h1234_5678);
    // extreme distance, ties and a single entry set
    send_entry(6'd5, 16'h8000, 16'h8000, 16'h7fff, 1'b0);
    send_entry(6'd6, 16'h7fff, 16'h7fff, 16'h8000, 1'b0);
    send_entry(6'd7, 16'h8000, 16'h8000, 16'h7fff, 1'b0);
    send_entry(6'd8, 16'h1234, 16'hfedc, 16'h0001, 1'b1);
    send_entry(6'd9, 16'h0010, 16'h0020, 16'h0030, 1'b1);
    settle();
    write_reg(REG_REF_X, 32'h0000_8000);
    write_reg(REG_REF_Y, 32'h0000_8000);
    write_reg(REG_REF_Z, 32'h0000_7fff);
    // store full, including a dropped last entry
    for (int i = 0; i < 34; i++)
      send_entry(ID_W'(i), POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                 i == 33);
    settle();
    while (sent < 260) begin
      if (sent > 120 && sent < 200) gaps_on = 1'b0;
      else gaps_on = 1'b1;
      tie_x = POS_W'($urandom);
      case ($urandom_range(9))
        0: n = $urandom_range(32, 36);
        1, 2: n = $urandom_range(9, 31);
        default: n = $urandom_range(1, 8);
      endcase
      random_set(n);
      if ($urandom_range(3) == 0) begin
        settle();
        write_reg(REG_REF_X, $urandom);
        write_reg(REG_REF_Y, $urandom);
        write_reg(REG_REF_Z, $urandom);
      end
    end
    settle();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
